FILE: src/bottom_up_merge_sorter_core_assert.svh
// Assertion helpers shared by the sorter RTL.
`ifndef BOTTOM_UP_MERGE_SORTER_CORE_ASSERT_SVH
`define BOTTOM_UP_MERGE_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BUMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BUMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bumsort_pkg.sv
`default_nettype none

package bumsort_pkg;

    // Width of one sorted value
    localparam int VALUE_W = 32;

    // Input request payload
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } bumsort_in_t;

    // Result request payload
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      dropped_any;
    } bumsort_out_t;

    // Commands from the front end to the merge engine
    typedef struct packed {
        logic sort_start;
        logic load_we;
    } bumsort_cmd_t;

    // Status from the merge engine
    typedef struct packed {
        logic busy;
        logic done;
    } bumsort_sts_t;

endpackage

`default_nettype wire

FILE: src/bottom_up_merge_sorter_core.sv
// Loading accepts one request per cycle; the set is closed by the request marked last.
// Sort: ceil(log2 N) passes over the shared compare/select unit, each with a
// setup step per merged segment and another at the pass end.
// Emit: each result goes through a registered memory read, then the output register.
// Reset (rst_n, async, active low) empties the buffer and clears the overflow flag.
`default_nettype none

module bottom_up_merge_sorter_core #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  bumsort_pkg::bumsort_in_t  item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output bumsort_pkg::bumsort_out_t result
);
    import bumsort_pkg::*;

    `include "bottom_up_merge_sorter_core_assert.svh"

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);

    typedef enum logic [3:0] {
        S_LOAD    = 4'b0001,
        S_SORT    = 4'b0010,
        S_EMIT_RD = 4'b0100,
        S_EMIT_WR = 4'b1000
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic          start_reg;
    logic [AW-1:0] emit_idx_reg;
    logic          result_valid_reg;
    bumsort_out_t  result_reg;

    bumsort_cmd_t  cmd;
    bumsort_sts_t  sts;
    logic signed [VALUE_W-1:0] rd_data;

    logic          item_accept;
    logic          has_room;
    logic          emit_last;
    logic          result_free;
    logic          emit_fire;

    assign item_ready  = (state_reg == S_LOAD);
    assign item_accept = item_valid && item_ready;
    assign has_room    = count_reg < CW'(MAX_ITEMS);
    assign emit_last   = (CW'(emit_idx_reg) + CW'(1)) == count_reg;
    assign result_free = !result_valid_reg || result_ready;
    assign emit_fire   = (state_reg == S_EMIT_WR) && result_free;

    assign cmd.load_we    = item_accept && has_room;
    assign cmd.sort_start = start_reg;

    bumsort_merge #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .count   (count_reg),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (item.value),
        .rd_addr (emit_idx_reg),
        .rd_data (rd_data)
    );

    // Load / sort / emit control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            start_reg        <= 1'b0;
            emit_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // Closing request kicks the merge engine
            start_reg <= item_accept && item.last_item;
            if (emit_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (item_accept)
                    begin
                        if (has_room)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (item.last_item)
                        begin
                            state_reg <= S_SORT;
                        end
                    end
                end
                S_SORT:
                begin
                    if (sts.done)
                    begin
                        emit_idx_reg <= '0;
                        state_reg    <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_WR;
                end
                S_EMIT_WR:
                begin
                    if (result_free)
                    begin
                        if (emit_last)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + AW'(1);
                            state_reg    <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            result_reg.sorted_value <= rd_data;
            result_reg.last_out     <= emit_last;
            result_reg.dropped_any  <= ovf_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `BUMS_ASSERT_NEXT(a_last_starts_sort, clk, rst_n, item_accept && item.last_item,
        start_reg && (state_reg == S_SORT), "closing request did not start the sort")
    `BUMS_ASSERT_NOW(a_ovf_only_full, clk, rst_n, ovf_reg,
        count_reg == CW'(MAX_ITEMS), "overflow flagged with buffer not full")
    `BUMS_ASSERT_NOW(a_engine_idle_load, clk, rst_n, state_reg == S_LOAD,
        !sts.busy, "merge engine busy while loading")
    `BUMS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= CW'(MAX_ITEMS), "item count beyond buffer depth")

endmodule

`default_nettype wire

FILE: src/bumsort_merge.sv
`default_nettype none

module bumsort_merge #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bumsort_pkg::bumsort_cmd_t             cmd,
    output bumsort_pkg::bumsort_sts_t             sts,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]        count,
    input  logic [$clog2(MAX_ITEMS)-1:0]          wr_addr,
    input  logic signed [bumsort_pkg::VALUE_W-1:0] wr_data,
    input  logic [$clog2(MAX_ITEMS)-1:0]          rd_addr,
    output logic signed [bumsort_pkg::VALUE_W-1:0] rd_data
);
    import bumsort_pkg::*;

    `include "bottom_up_merge_sorter_core_assert.svh"

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int RW = CW + 1;

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_PASS = 3'b010,
        M_MRG  = 3'b100
    } mstate_t;

    mstate_t        state_reg;
    logic           src_reg;
    logic           done_reg;
    logic [CW-1:0]  n_reg;
    logic [RW-1:0]  run_reg;
    logic [RW-1:0]  pos_reg;
    logic [CW-1:0]  a_reg;
    logic [CW-1:0]  b_reg;
    logic [CW-1:0]  k_reg;
    logic [CW-1:0]  mid_reg;
    logic [CW-1:0]  hi_reg;

    // Ping-pong banks, two registered read ports each
    logic signed [VALUE_W-1:0] bank0_mem [MAX_ITEMS];
    logic signed [VALUE_W-1:0] bank1_mem [MAX_ITEMS];
    logic signed [VALUE_W-1:0] rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;

    logic [RW-1:0]  n_ext;
    logic [RW-1:0]  seg_mid_w, seg_hi_w, run_dbl;
    logic [CW-1:0]  seg_mid, seg_hi;
    logic           a_live, b_live, take_a;
    logic [CW-1:0]  a_next, b_next;
    logic signed [VALUE_W-1:0] da, db, mrg_data;
    logic [AW-1:0]  ra, rb;
    logic           we0, we1;
    logic signed [VALUE_W-1:0] wd0;
    logic [AW-1:0]  wa0;

    // Segment bounds clipped to the set size
    assign n_ext     = {1'b0, n_reg};
    assign seg_mid_w = pos_reg + run_reg;
    assign run_dbl   = run_reg << 1;
    assign seg_hi_w  = pos_reg + run_dbl;
    assign seg_mid   = (seg_mid_w < n_ext) ? seg_mid_w[CW-1:0] : n_reg;
    assign seg_hi    = (seg_hi_w < n_ext) ? seg_hi_w[CW-1:0] : n_reg;

    // Shared compare/select step; left run wins ties
    assign da       = src_reg ? rd1a_reg : rd0a_reg;
    assign db       = src_reg ? rd1b_reg : rd0b_reg;
    assign a_live   = a_reg < mid_reg;
    assign b_live   = b_reg < hi_reg;
    assign take_a   = !b_live || (a_live && (da <= db));
    assign mrg_data = take_a ? da : db;
    assign a_next   = a_reg + CW'(take_a);
    assign b_next   = b_reg + CW'(!take_a);

    // Read address select
    always_comb
    begin
        unique case (state_reg)
            M_PASS:
            begin
                ra = pos_reg[AW-1:0];
                rb = seg_mid[AW-1:0];
            end
            M_MRG:
            begin
                ra = a_next[AW-1:0];
                rb = b_next[AW-1:0];
            end
            default:
            begin
                ra = rd_addr;
                rb = rd_addr;
            end
        endcase
    end

    // Write port select: load fills bank 0, merges write the other bank
    assign we1 = (state_reg == M_MRG) && !src_reg;
    assign we0 = ((state_reg == M_MRG) && src_reg) || cmd.load_we;
    assign wd0 = (state_reg == M_MRG) ? mrg_data : wr_data;
    assign wa0 = (state_reg == M_MRG) ? k_reg[AW-1:0] : wr_addr;

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            bank0_mem[wa0] <= wd0;
        end
        rd0a_reg <= bank0_mem[ra];
        rd0b_reg <= bank0_mem[rb];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            bank1_mem[k_reg[AW-1:0]] <= mrg_data;
        end
        rd1a_reg <= bank1_mem[ra];
        rd1b_reg <= bank1_mem[rb];
    end

    // Pass / segment sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            src_reg   <= 1'b0;
            done_reg  <= 1'b0;
            n_reg     <= '0;
            run_reg   <= '0;
            pos_reg   <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            k_reg     <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (cmd.sort_start)
                    begin
                        n_reg   <= count;
                        src_reg <= 1'b0;
                        run_reg <= RW'(1);
                        pos_reg <= '0;
                        if (count < CW'(2))
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= M_PASS;
                        end
                    end
                end
                M_PASS:
                begin
                    if (pos_reg < n_ext)
                    begin
                        a_reg     <= pos_reg[CW-1:0];
                        k_reg     <= pos_reg[CW-1:0];
                        b_reg     <= seg_mid;
                        mid_reg   <= seg_mid;
                        hi_reg    <= seg_hi;
                        state_reg <= M_MRG;
                    end
                    else
                    begin
                        src_reg <= ~src_reg;
                        run_reg <= run_dbl;
                        pos_reg <= '0;
                        if (run_dbl >= n_ext)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= M_IDLE;
                        end
                    end
                end
                M_MRG:
                begin
                    a_reg <= a_next;
                    b_reg <= b_next;
                    k_reg <= k_reg + CW'(1);
                    if (k_reg + CW'(1) == hi_reg)
                    begin
                        pos_reg   <= {1'b0, hi_reg};
                        state_reg <= M_PASS;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign sts.busy = (state_reg != M_IDLE);
    assign sts.done = done_reg;
    assign rd_data  = src_reg ? rd1a_reg : rd0a_reg;

    `BUMS_ASSERT_NOW(a_mrg_k_in_seg, clk, rst_n, state_reg == M_MRG,
        k_reg < hi_reg, "merge output index past segment end")
    `BUMS_ASSERT_NOW(a_mrg_ptr_bound, clk, rst_n, state_reg == M_MRG,
        (a_reg <= mid_reg) && (b_reg <= hi_reg), "merge read pointer past run end")
    `BUMS_ASSERT_NOW(a_start_idle, clk, rst_n, cmd.sort_start,
        state_reg == M_IDLE, "sort started while engine busy")
    `BUMS_ASSERT_NOW(a_load_idle, clk, rst_n, cmd.load_we,
        state_reg == M_IDLE, "load write while merging")

endmodule

`default_nettype wire
